// ===== sv/afdc_pkg.sv =====
// Shared types and constants for the box frustum and distance cull unit.
package afdc_pkg;

  // Fixed field widths of the beats and registers.
  localparam int COORD_W    = 16;
  localparam int COEF_W     = 16;
  localparam int PLANE_W    = 64;
  localparam int PLANE_REGS = 6;
  localparam int CAM_W      = 48;
  localparam int DIST_W     = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int D_SHIFT    = 14;

  // Datapath widths derived from the coordinate and coefficient widths.
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int GAP_W      = COORD_W;
  localparam int GAP_SQ_W   = 2 * GAP_W;
  localparam int NEAR_W     = GAP_SQ_W + 2;
  localparam int CTR_W      = COORD_W + 2;
  localparam int CTR_SQ_W   = 2 * CTR_W - 2;
  localparam int TWICE_W    = CTR_SQ_W + 2;

  // Result buffer depth: covers the items in flight plus one waiting beat.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd7;

  typedef enum logic [1:0] {
    CULL_NONE    = 2'd0,
    CULL_FRUSTUM = 2'd1,
    CULL_DIST    = 2'd2
  } cull_reason_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic                      has_bounds;
  } in_t;

  typedef struct packed {
    logic              visible;
    cull_reason_t      cull_reason;
    logic [DIST_W-1:0] center_dist_sq;
  } out_t;

  typedef logic [PLANE_REGS-1:0][PLANE_W-1:0] plane_bank_t;

  // Configuration state handed from the register file to the datapath.
  typedef struct packed {
    plane_bank_t       planes;
    logic [CAM_W-1:0]  camera;
    logic [DIST_W-1:0] max_dist_sq;
  } cfg_t;

endpackage

// ===== sv/aabb_frustum_distance_cull_unit.sv =====
// Top level of the box frustum and distance cull unit.
//
// Usage: each input beat carries one box (min and max corners, signed Q11.4)
// and a has_bounds flag. The box is tested against the first NUM_PLANES planes
// by the positive-vertex rule, then against the squared distance limit, and
// one result beat comes back per box: visible, cull reason and the squared
// camera distance to the box centre as a sort key.
// The configuration port writes the six planes, the camera position and the
// distance limit; write it only while no box is in flight.
// Three registers lie between an accepted input beat and its result: input
// register, product register, then the decision written into the result
// buffer, from which out_valid rises and the result can be taken. A new box
// is accepted every cycle while results are taken.
// in_stall rises only when the four-entry result buffer, counting the boxes
// still in the pipeline, would be full; a stalled receiver therefore fills
// the buffer and then holds off the sender, and no beat is lost.
// Reset (synchronous, active low) clears all configuration registers to zero,
// empties the pipeline and the buffer.
module aabb_frustum_distance_cull_unit #(
  parameter int NUM_PLANES = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  afdc_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output afdc_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [afdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afdc_pkg::PLANE_W-1:0]          cfg_wdata
);
  import afdc_pkg::*;

  cfg_t             cfg_r;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             in_fire;
  logic             out_fire;
  logic             res_valid;
  out_t             res_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          cfg_r.planes[i] <= cfg_wdata;
        end
      end
      if (cfg_index == REG_CAMERA) begin
        cfg_r.camera <= cfg_wdata[CAM_W-1:0];
      end
      if (cfg_index == REG_MAX_DIST) begin
        cfg_r.max_dist_sq <= cfg_wdata[DIST_W-1:0];
      end
    end
  end

  // Occupancy counts boxes in the pipeline plus beats held in the buffer.
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign occ_nxt  = occ_r + OCC_W'(in_fire) - OCC_W'(out_fire);
  assign in_stall = (occ_r == OCC_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  afdc_cull_core #(
    .NUM_PLANES (NUM_PLANES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  afdc_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res_data),
    .rd_en    (out_fire),
    .rd_valid (out_valid),
    .rd_data  (out_data)
  );

`ifndef SYNTH
  // The occupancy count never passes the buffer depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(FIFO_DEPTH))
    else $error("occupancy above result buffer depth");

  // A waiting result beat is always counted in the occupancy.
  a_occ_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result beat present with zero occupancy");

  // Visibility and cull reason agree on every result beat.
  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.visible == (out_data.cull_reason == CULL_NONE)))
    else $error("visible flag disagrees with cull reason");

  // A culled box never carries a sort key.
  a_culled_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.visible) |-> out_data.center_dist_sq == '0)
    else $error("culled box with nonzero sort key");
`endif

endmodule

// ===== sv/afdc_cull_core.sv =====
// Datapath: box input register, product register, then the combinational cull decision.
module afdc_cull_core #(
  parameter int NUM_PLANES = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  afdc_pkg::in_t  in_data,
  input  afdc_pkg::cfg_t cfg,
  output logic          res_valid,
  output afdc_pkg::out_t res_data
);
  import afdc_pkg::*;

  logic                      s1_valid_r;
  logic signed [COORD_W-1:0] s1_lo_r [3];
  logic signed [COORD_W-1:0] s1_hi_r [3];
  logic                      s1_bounds_r;

  logic                      s2_valid_r;
  logic signed [PROD_W-1:0]  s2_prod_r [NUM_PLANES][3];
  logic [GAP_SQ_W-1:0]       s2_gap_sq_r [3];
  logic [CTR_SQ_W-1:0]       s2_ctr_sq_r [3];
  logic                      s2_bounds_r;

  logic signed [COORD_W-1:0] cam [3];
  logic [NUM_PLANES-1:0]     plane_out;
  logic                      outside;
  logic [NEAR_W-1:0]         near_sq;
  logic [TWICE_W-1:0]        twice_sq;
  logic                      too_far;

  // Valid bits of the two pipeline stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Input register; a point without bounds uses its minimum corner as maximum.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lo_r[0]  <= in_data.min_x;
      s1_lo_r[1]  <= in_data.min_y;
      s1_lo_r[2]  <= in_data.min_z;
      s1_hi_r[0]  <= in_data.has_bounds ? in_data.max_x : in_data.min_x;
      s1_hi_r[1]  <= in_data.has_bounds ? in_data.max_y : in_data.min_y;
      s1_hi_r[2]  <= in_data.has_bounds ? in_data.max_z : in_data.min_z;
      s1_bounds_r <= in_data.has_bounds;
    end
  end

  // Per-axis camera position and the distance terms that need a square.
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [COORD_W:0]   lo_ext;
    logic signed [COORD_W:0]   hi_ext;
    logic signed [COORD_W:0]   cam_ext;
    logic signed [COORD_W:0]   gap;
    logic signed [CTR_W-1:0]   ctr;
    logic signed [2*CTR_W-1:0] ctr_sq;

    assign cam[k]  = signed'(cfg.camera[COORD_W*k +: COORD_W]);
    assign lo_ext  = {s1_lo_r[k][COORD_W-1], s1_lo_r[k]};
    assign hi_ext  = {s1_hi_r[k][COORD_W-1], s1_hi_r[k]};
    assign cam_ext = {cam[k][COORD_W-1], cam[k]};

    // Distance from the camera to the nearest point of the box along this axis.
    always_comb begin
      priority if (cam_ext < lo_ext) begin
        gap = lo_ext - cam_ext;
      end else if (cam_ext > hi_ext) begin
        gap = cam_ext - hi_ext;
      end else begin
        gap = '0;
      end
    end

    // Twice the centre offset, kept exact so the square can be quartered later.
    assign ctr    = CTR_W'(lo_ext) + CTR_W'(hi_ext) - (CTR_W'(cam_ext) <<< 1);
    assign ctr_sq = ctr * ctr;

    always_ff @(posedge clk) begin
      if (s1_valid_r) begin
        s2_gap_sq_r[k] <= gap[GAP_W-1:0] * gap[GAP_W-1:0];
        s2_ctr_sq_r[k] <= ctr_sq[CTR_SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_bounds_r <= s1_bounds_r;
    end
  end

  // Plane lanes: positive vertex products, then the signed plane sum.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    logic signed [ACC_W-1:0] acc;
    logic signed [COEF_W-1:0] d_coef;

    for (genvar k = 0; k < 3; k++) begin : g_term
      logic signed [COEF_W-1:0]  coef;
      logic signed [COORD_W-1:0] vtx;

      assign coef = signed'(cfg.planes[p][COEF_W*k +: COEF_W]);
      // A zero coefficient counts as non-negative and takes the maximum corner.
      assign vtx  = coef[COEF_W-1] ? s1_lo_r[k] : s1_hi_r[k];

      always_ff @(posedge clk) begin
        if (s1_valid_r) begin
          s2_prod_r[p][k] <= coef * vtx;
        end
      end
    end

    assign d_coef = signed'(cfg.planes[p][3*COEF_W +: COEF_W]);
    assign acc    = (ACC_W'(d_coef) <<< D_SHIFT)
                  + ACC_W'(s2_prod_r[p][0])
                  + ACC_W'(s2_prod_r[p][1])
                  + ACC_W'(s2_prod_r[p][2]);
    assign plane_out[p] = acc[ACC_W-1];
  end

  assign outside = |plane_out;

  // Nearest-point distance test, only for real boxes with a nonzero limit.
  assign near_sq = NEAR_W'(s2_gap_sq_r[0]) + NEAR_W'(s2_gap_sq_r[1])
                 + NEAR_W'(s2_gap_sq_r[2]);
  assign too_far = s2_bounds_r && (cfg.max_dist_sq != '0)
                 && (near_sq > NEAR_W'(cfg.max_dist_sq));

  // The doubled-resolution sum quartered; its range never passes the key width.
  assign twice_sq = TWICE_W'(s2_ctr_sq_r[0]) + TWICE_W'(s2_ctr_sq_r[1])
                  + TWICE_W'(s2_ctr_sq_r[2]);

  // Result beat; a culled box carries a zero sort key.
  always_comb begin
    res_valid = s2_valid_r;
    priority if (outside) begin
      res_data.visible        = 1'b0;
      res_data.cull_reason    = CULL_FRUSTUM;
      res_data.center_dist_sq = '0;
    end else if (too_far) begin
      res_data.visible        = 1'b0;
      res_data.cull_reason    = CULL_DIST;
      res_data.center_dist_sq = '0;
    end else begin
      res_data.visible        = 1'b1;
      res_data.cull_reason    = CULL_NONE;
      res_data.center_dist_sq = twice_sq[DIST_W+1:2];
    end
  end

endmodule

// ===== sv/afdc_out_fifo.sv =====
// Small result buffer that holds finished beats while the receiver stalls.
module afdc_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  afdc_pkg::out_t wr_data,
  input  logic           rd_en,
  output logic           rd_valid,
  output afdc_pkg::out_t rd_data
);
  import afdc_pkg::*;

  out_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [OCC_W-1:0]   count_r;

  // Pointers and fill count; the writer never pushes into a full buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + OCC_W'(wr_en) - OCC_W'(rd_en);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

endmodule
